// ===== hdl/ffwc_pkg.sv =====
`timescale 1ns / 1ps

package ffwc_pkg;

  localparam int TAPS      = 5;
  localparam int RAW_W     = 16;
  localparam int WT_W      = 16;
  localparam int TGT_W     = 13;
  localparam int ACT_W     = 2;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam int POS_W     = $clog2(TAPS);
  localparam int SUM_W     = RAW_W + $clog2(TAPS);
  // Divide by TAPS as multiply by rounded-up reciprocal; exact for any SUM_W-bit sum
  localparam int DIV_SHIFT = SUM_W + $clog2(TAPS);
  localparam int MULT_W    = SUM_W + 1;
  localparam int PROD_W    = SUM_W + MULT_W;
  localparam logic [MULT_W-1:0] DIV_MULT =
    MULT_W'(((64'd1 << DIV_SHIFT) + 64'(TAPS) - 64'd1) / 64'(TAPS));

  localparam logic [RAW_W-1:0] RAW_BIAS   = 16'd10001;
  localparam logic [WT_W-1:0]  MAX_WEIGHT = 16'd4999;

  typedef enum logic [ACT_W-1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_START  = 2'd1,
    ACT_ABORT  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    STOP_NONE   = 2'd0,
    STOP_TARGET = 2'd1,
    STOP_BELOW  = 2'd2,
    STOP_ABORT  = 2'd3
  } stop_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILL_TARGET = 1'b0,
    CFG_ZERO_OFFSET = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [TGT_W-1:0] fill_target;
    logic [WT_W-1:0]  zero_offset;
  } cfg_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [WT_W-1:0]  gross;
  } wt_item_t;

endpackage

// ===== hdl/ffwc_in_if.sv =====
`timescale 1ns / 1ps

interface ffwc_in_if;
  logic                        valid;
  logic                        ready;
  logic [ffwc_pkg::ACT_W-1:0]  action;
  logic [ffwc_pkg::RAW_W-1:0]  raw_count;

  modport source(output valid, action, raw_count, input ready);
  modport sink(input valid, action, raw_count, output ready);
endinterface

// ===== hdl/ffwc_out_if.sv =====
`timescale 1ns / 1ps

interface ffwc_out_if;
  logic                       valid;
  logic                       ready;
  logic [ffwc_pkg::WT_W-1:0]  gross_weight;
  logic [ffwc_pkg::WT_W-1:0]  net_weight;
  logic                       valve_open;
  logic [1:0]                 stop_reason;
  logic                       over_range;

  modport source(output valid, gross_weight, net_weight, valve_open, stop_reason, over_range,
                 input ready);
  modport sink(input valid, gross_weight, net_weight, valve_open, stop_reason, over_range,
               output ready);
endinterface

// ===== hdl/ffwc_filter.sv =====
`timescale 1ns / 1ps

module ffwc_filter (
  input  logic               clk,
  input  logic               rst_n,
  input  ffwc_pkg::cfg_t     cfg,
  ffwc_in_if.sink            in_ch,
  output logic               wt_valid,
  input  logic               wt_ready,
  output ffwc_pkg::wt_item_t wt_item
);
  import ffwc_pkg::*;

  logic [RAW_W-1:0]  ring_r [TAPS];
  logic [POS_W-1:0]  pos_r;
  logic [SUM_W-1:0]  sum_r;

  logic              s1_v_r;
  logic [ACT_W-1:0]  s1_act_r;
  logic [SUM_W-1:0]  s1_sum_r;

  logic              s2_v_r;
  wt_item_t          s2_item_r;

  logic              s1_rdy;
  logic              s2_rdy;
  logic              in_acc;
  logic              do_sample;
  logic [RAW_W-1:0]  smp;
  logic [SUM_W-1:0]  sum_nxt;
  logic [POS_W-1:0]  pos_nxt;
  logic [PROD_W-1:0] prod;
  logic [WT_W-1:0]   avg;
  logic [WT_W-1:0]   quarter;
  logic [WT_W-1:0]   gross;

  assign s2_rdy      = !s2_v_r || wt_ready;
  assign s1_rdy      = !s1_v_r || s2_rdy;
  assign in_ch.ready = s1_rdy;
  assign in_acc      = in_ch.valid && s1_rdy;
  assign do_sample   = in_acc && (in_ch.action == ACT_SAMPLE);

  always_comb begin
    smp     = in_ch.raw_count - RAW_BIAS;
    sum_nxt = sum_r + SUM_W'(smp) - SUM_W'(ring_r[pos_r]);
    pos_nxt = (pos_r == POS_W'(TAPS - 1)) ? '0 : pos_r + POS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        ring_r[i] <= '0;
      end
      pos_r <= '0;
      sum_r <= '0;
    end else if (do_sample) begin
      ring_r[pos_r] <= smp;
      pos_r         <= pos_nxt;
      sum_r         <= sum_nxt;
    end
  end

  // moving average / TAPS, round quarter, remove zero offset
  always_comb begin
    prod    = PROD_W'(s1_sum_r) * PROD_W'(DIV_MULT);
    avg     = prod[DIV_SHIFT +: WT_W];
    quarter = {2'b00, avg[WT_W-1:2]} + WT_W'(avg[1]);
    gross   = quarter - cfg.zero_offset;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_r <= in_acc;
      end
      if (s2_rdy) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_act_r <= in_ch.action;
      s1_sum_r <= sum_nxt;
    end
    if (s1_v_r && s2_rdy) begin
      s2_item_r.action <= s1_act_r;
      s2_item_r.gross  <= gross;
    end
  end

  assign wt_valid = s2_v_r;
  assign wt_item  = s2_item_r;

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(TAPS - 1))
    else $error("ring position out of range");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && !wt_ready |=> s2_v_r && $stable(s2_item_r))
    else $error("stalled weight word changed");
`endif

endmodule

// ===== hdl/ffwc_ctrl.sv =====
`timescale 1ns / 1ps

module ffwc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  ffwc_pkg::cfg_t     cfg,
  input  logic               wt_valid,
  output logic               wt_ready,
  input  ffwc_pkg::wt_item_t wt_item,
  ffwc_out_if.source         out_ch
);
  import ffwc_pkg::*;

  logic             filling_r;
  logic [WT_W-1:0]  tare_r;
  logic [WT_W-1:0]  prev_r;

  logic             filling_nxt;
  logic [WT_W-1:0]  tare_nxt;
  logic [WT_W-1:0]  prev_nxt;

  logic             out_v_r;
  logic [WT_W-1:0]  gross_r;
  logic [WT_W-1:0]  net_r;
  logic             valve_r;
  stop_t            reason_r;
  logic             over_r;

  logic             out_rdy;
  logic             adv;
  logic [WT_W-1:0]  gross_sel;
  logic [WT_W-1:0]  net_nxt;
  logic [WT_W-1:0]  rise;
  logic [WT_W-1:0]  limit;
  stop_t            reason_nxt;

  assign out_rdy  = !out_v_r || out_ch.ready;
  assign wt_ready = out_rdy;
  assign adv      = wt_valid && out_rdy;

  always_comb begin
    filling_nxt = filling_r;
    tare_nxt    = tare_r;
    prev_nxt    = prev_r;
    gross_sel   = prev_r;
    reason_nxt  = STOP_NONE;
    rise        = wt_item.gross - prev_r;
    limit       = tare_r + WT_W'(cfg.fill_target) - rise;
    case (wt_item.action)
      ACT_SAMPLE: begin
        gross_sel = wt_item.gross;
        prev_nxt  = wt_item.gross;
        if (filling_r) begin
          if (wt_item.gross >= limit) begin
            filling_nxt = 1'b0;
            reason_nxt  = STOP_TARGET;
          end else if (wt_item.gross < tare_r) begin
            filling_nxt = 1'b0;
            reason_nxt  = STOP_BELOW;
          end
        end else begin
          tare_nxt = wt_item.gross;
        end
      end
      ACT_START: begin
        filling_nxt = 1'b1;
      end
      ACT_ABORT: begin
        if (filling_r) begin
          filling_nxt = 1'b0;
          reason_nxt  = STOP_ABORT;
        end
      end
      default: ;
    endcase
    // tare only moves while idle, so the current tare is the one to net against
    net_nxt = (filling_r && gross_sel >= tare_r) ? gross_sel - tare_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filling_r <= 1'b0;
      tare_r    <= '0;
      prev_r    <= '0;
      out_v_r   <= 1'b0;
    end else begin
      if (adv) begin
        filling_r <= filling_nxt;
        tare_r    <= tare_nxt;
        prev_r    <= prev_nxt;
      end
      if (out_rdy) begin
        out_v_r <= wt_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gross_r  <= gross_sel;
      net_r    <= net_nxt;
      valve_r  <= filling_nxt;
      reason_r <= reason_nxt;
      over_r   <= (gross_sel > MAX_WEIGHT);
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.gross_weight = gross_r;
  assign out_ch.net_weight   = net_r;
  assign out_ch.valve_open   = valve_r;
  assign out_ch.stop_reason  = reason_r;
  assign out_ch.over_range   = over_r;

`ifndef SYNTHESIS
  a_stop_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && reason_r != STOP_NONE |-> !valve_r)
    else $error("stop reported with valve open");

  a_start_opens: assert property (@(posedge clk) disable iff (!rst_n)
    adv && wt_item.action == ACT_START |=> filling_r && valve_r)
    else $error("start did not open valve");

  a_stop_needs_fill: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !filling_r |=> reason_r == STOP_NONE)
    else $error("stop reported while idle");
`endif

endmodule

// ===== hdl/filtered_fill_weight_controller_core.sv =====
`timescale 1ns / 1ps
// Each accepted input word passes three register stages (ring/sum update, divide by
//   taps and offset, fill decision + output register). Throughput: one word per cycle
//   when not stalled; stages advance independently, so bubbles absorb output stalls.
//   Reset (rst_n low, synchronous) clears ring, sum, position, fill state, tare, last
//   weight and both config registers to zero.
module filtered_fill_weight_controller_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ffwc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ffwc_pkg::CFG_W-1:0]       cfg_data,
  ffwc_in_if.sink                          in_ch,
  ffwc_out_if.source                       out_ch
);
  import ffwc_pkg::*;

  cfg_t     cfg_r;
  logic     wt_valid;
  logic     wt_ready;
  wt_item_t wt_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FILL_TARGET: cfg_r.fill_target <= cfg_data[TGT_W-1:0];
        CFG_ZERO_OFFSET: cfg_r.zero_offset <= cfg_data[WT_W-1:0];
        default: ;
      endcase
    end
  end

  ffwc_filter u_filter (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_ch    (in_ch),
    .wt_valid (wt_valid),
    .wt_ready (wt_ready),
    .wt_item  (wt_item)
  );

  ffwc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .wt_valid (wt_valid),
    .wt_ready (wt_ready),
    .wt_item  (wt_item),
    .out_ch   (out_ch)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import ffwc_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 500000;
  localparam int DRAIN_CYCLES = 6;

  typedef struct packed {
    logic [WT_W-1:0] gross;
    logic [WT_W-1:0] net;
    logic            valve;
    stop_t           reason;
    logic            over;
  } fill_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  ffwc_in_if  in_ch();
  ffwc_out_if out_ch();

  filtered_fill_weight_controller_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // scale state as the block should hold it
  logic [WT_W-1:0]  avg_ring [TAPS];
  int unsigned      ring_idx;
  int unsigned      ring_total;
  logic             is_filling;
  logic [WT_W-1:0]  tare_wt;
  logic [WT_W-1:0]  last_wt;
  logic [TGT_W-1:0] tgt_reg;
  logic [WT_W-1:0]  offset_reg;

  fill_result_t pending_results[$];

  int errors;
  int words_sent;
  int words_checked;
  int cycle_cnt;
  int tx_max_gap;
  int rx_max_gap;
  int rx_hold_cycles;
  int stops_target;
  int stops_below;
  int stops_abort;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d words outstanding", $time, pending_results.size());
      $display("[filtered_fill_weight_controller_core] ERROR");
      $finish;
    end
  end

  function automatic void reset_scale();
    for (int i = 0; i < TAPS; i++) avg_ring[i] = '0;
    ring_idx   = 0;
    ring_total = 0;
    is_filling = 1'b0;
    tare_wt    = '0;
    last_wt    = '0;
    tgt_reg    = '0;
    offset_reg = '0;
  endfunction

  function automatic fill_result_t predict_fill(input logic [ACT_W-1:0] act,
                                                input logic [RAW_W-1:0] raw);
    fill_result_t r;
    logic [WT_W-1:0] v;
    logic [WT_W-1:0] rise;
    logic [WT_W-1:0] lim;
    logic was_filling;
    int unsigned avg;
    int unsigned q;
    was_filling = is_filling;
    r.gross  = last_wt;
    r.net    = '0;
    r.reason = STOP_NONE;
    if (act == ACT_SAMPLE) begin
      v = raw - RAW_BIAS;
      ring_total = ring_total + v - avg_ring[ring_idx];
      avg_ring[ring_idx] = v;
      ring_idx = (ring_idx == TAPS - 1) ? 0 : ring_idx + 1;
      avg = ring_total / TAPS;
      q = avg >> 2;
      if ((avg % 4) > 1) q++;
      r.gross = q - offset_reg;
      if (is_filling) begin
        rise = r.gross - last_wt;
        lim  = tare_wt + tgt_reg - rise;
        if (r.gross >= lim) begin
          is_filling = 1'b0;
          r.reason = STOP_TARGET;
        end else if (r.gross < tare_wt) begin
          is_filling = 1'b0;
          r.reason = STOP_BELOW;
        end
      end else begin
        tare_wt = r.gross;
      end
      last_wt = r.gross;
    end else if (act == ACT_START) begin
      is_filling = 1'b1;
    end else if (act == ACT_ABORT && is_filling) begin
      is_filling = 1'b0;
      r.reason = STOP_ABORT;
    end
    if (was_filling && r.gross >= tare_wt) r.net = r.gross - tare_wt;
    r.valve = is_filling;
    r.over  = (r.gross > MAX_WEIGHT);
    return r;
  endfunction

  // entered and left at a falling edge
  task automatic send_word(input logic [ACT_W-1:0] act, input logic [RAW_W-1:0] raw);
    fill_result_t r;
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    repeat (gap) @(negedge clk);
    in_ch.valid     = 1'b1;
    in_ch.action    = act;
    in_ch.raw_count = raw;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    r = predict_fill(act, raw);
    pending_results.push_back(r);
    if (act != ACT_UNUSED) words_sent++;
    case (r.reason)
      STOP_TARGET: stops_target++;
      STOP_BELOW:  stops_below++;
      STOP_ABORT:  stops_abort++;
      default: ;
    endcase
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_FILL_TARGET) tgt_reg = data[TGT_W-1:0];
    else offset_reg = data;
  endtask

  task automatic check_field(input string name, input logic [WT_W-1:0] exp_v,
                             input logic [WT_W-1:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    fill_result_t exp_r;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, gross %h", $time, out_ch.gross_weight);
      end else begin
        exp_r = pending_results.pop_front();
        check_field("gross_weight", exp_r.gross, out_ch.gross_weight);
        check_field("net_weight", exp_r.net, out_ch.net_weight);
        check_field("valve_open", WT_W'(exp_r.valve), WT_W'(out_ch.valve_open));
        check_field("stop_reason", WT_W'(exp_r.reason), WT_W'(out_ch.stop_reason));
        check_field("over_range", WT_W'(exp_r.over), WT_W'(out_ch.over_range));
        words_checked++;
      end
    end
  end

  // result side: random stalls plus an optional long hold-off
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ch.ready = 1'b0;
        repeat (rx_hold_cycles) @(negedge clk);
        rx_hold_cycles = 0;
      end
      gap = $urandom_range(0, rx_max_gap);
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      @(negedge clk);
    end
  end

  task automatic test_directed();
    tx_max_gap = 11;
    rx_max_gap = 11;
    send_word(ACT_SAMPLE, 16'h0000);
    send_word(ACT_SAMPLE, 16'hFFFF);
    send_word(ACT_SAMPLE, RAW_BIAS);
    send_word(ACT_UNUSED, 16'h5A5A);
    send_word(ACT_ABORT, 16'hA5A5);
    send_word(ACT_START, 16'h0000);
    send_word(ACT_START, 16'hFFFF);
    send_word(ACT_SAMPLE, 16'hFFFF);
    send_word(ACT_START, 16'h0000);
    send_word(ACT_ABORT, 16'h0000);
    wait_idle();
    write_reg(CFG_FILL_TARGET, 16'd40);
    write_reg(CFG_ZERO_OFFSET, 16'd2);
    repeat (5) send_word(ACT_SAMPLE, 16'd12001);
    send_word(ACT_START, 16'h0000);
    send_word(ACT_SAMPLE, 16'd11001);
    send_word(ACT_START, 16'h0000);
    send_word(ACT_SAMPLE, 16'd13001);
    send_word(ACT_SAMPLE, 16'd13801);
    send_word(ACT_SAMPLE, 16'd14601);
    wait_idle();
  endtask

  task automatic run_fill_cycle();
    int raw;
    int base_hi;
    int step_max;
    int n;
    int r;
    base_hi  = 63535 - int'(tgt_reg) * 4;
    raw      = $urandom_range(int'(RAW_BIAS), base_hi);
    step_max = (int'(tgt_reg) * 4) / $urandom_range(4, 20) + 2;
    repeat ($urandom_range(3, 7)) send_word(ACT_SAMPLE, RAW_W'(raw + $urandom_range(0, 3)));
    if ($urandom_range(0, 9) == 0) send_word(ACT_ABORT, RAW_W'($urandom));
    send_word(ACT_START, RAW_W'($urandom));
    if ($urandom_range(0, 9) == 0) send_word(ACT_START, RAW_W'($urandom));
    n = 0;
    while (is_filling && n < 60) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_word(ACT_ABORT, RAW_W'($urandom));
      end else if (r < 6) begin
        send_word(ACT_UNUSED, RAW_W'($urandom));
      end else if (r < 9) begin
        send_word(ACT_START, RAW_W'($urandom));
      end else begin
        if (r < 14) raw = raw - $urandom_range(0, 400);
        else raw = raw + $urandom_range(0, step_max);
        if (raw < 0) raw = 0;
        if (raw > 65535) raw = 65535;
        send_word(ACT_SAMPLE, RAW_W'(raw));
      end
      n++;
    end
    if (is_filling) send_word(ACT_ABORT, RAW_W'($urandom));
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] tgt, input logic [CFG_W-1:0] ofs,
                           input int tx_gap, input int rx_gap, input int n_words);
    int stop_at;
    wait_idle();
    write_reg(CFG_FILL_TARGET, tgt);
    write_reg(CFG_ZERO_OFFSET, ofs);
    tx_max_gap = tx_gap;
    rx_max_gap = rx_gap;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 5))
          send_word(ACT_W'($urandom_range(0, 3)), RAW_W'($urandom));
      end else begin
        run_fill_cycle();
      end
    end
  endtask

  task automatic test_random_fills();
    run_phase(16'd4999, 16'd0, 11, 11, 225);
    run_phase(16'd0, 16'hFFFF, 11, 11, 225);
    run_phase(16'hFFFF, 16'd0, 0, 0, 225);
    run_phase(CFG_W'($urandom_range(0, 4999)), CFG_W'($urandom), 11, 0, 225);
    run_phase(CFG_W'($urandom_range(0, 4999)), 16'd0, 0, 11, 225);
    run_phase(16'd1, CFG_W'($urandom_range(0, 2000)), 11, 11, 225);
    run_phase(CFG_W'($urandom), CFG_W'($urandom), 3, 3, 225);
    run_phase(16'd4999, 16'hFFFF, 11, 11, 225);
  endtask

  task automatic test_output_stall();
    wait_idle();
    tx_max_gap = 0;
    rx_hold_cycles = 200;
    repeat (30) send_word(ACT_W'($urandom_range(0, 2)), RAW_W'($urandom));
    tx_max_gap = 11;
    rx_max_gap = 11;
    wait_idle();
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_FILL_TARGET;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.action   = ACT_SAMPLE;
    in_ch.raw_count = '0;
    errors         = 0;
    words_sent     = 0;
    words_checked  = 0;
    cycle_cnt      = 0;
    tx_max_gap     = 0;
    rx_max_gap     = 0;
    rx_hold_cycles = 0;
    stops_target   = 0;
    stops_below    = 0;
    stops_abort    = 0;
    reset_scale();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_output_stall();
    test_random_fills();
    test_output_stall();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: %0d result words never arrived", $time, pending_results.size());
    end
    $display("Sent %0d words and checked %0d results across 10 register settings.",
             words_sent, words_checked);
    $display("Fills ended: %0d at target, %0d below tare, %0d aborted.",
             stops_target, stops_below, stops_abort);
    if (errors == 0) begin
      $display("[filtered_fill_weight_controller_core] OK");
    end else begin
      $display("[filtered_fill_weight_controller_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ffwc_pkg.sv
hdl/ffwc_in_if.sv
hdl/ffwc_out_if.sv
hdl/ffwc_filter.sv
hdl/ffwc_ctrl.sv
hdl/filtered_fill_weight_controller_core.sv
tb/tb_top.sv
